>>> sv/tlptm_pkg.sv
// Shared types, codes and default sizes of the two-level page table manager.
`default_nettype none

package tlptm_pkg;

	// Default geometry.
	localparam int DEF_ADDRESS_BITS      = 32;
	localparam int DEF_PAGE_BITS         = 12;
	localparam int DEF_SECOND_INDEX_BITS = 10;
	localparam int DEF_TABLE_POOL        = 64;

	// Fixed field widths.
	localparam int FRAME_W     = 21;
	localparam int PERM_W      = 3;
	localparam int RAM_BASE_W  = 20;
	localparam int RAM_SIZE_W  = 33;
	localparam int CFG_W       = 33;
	localparam int VA_W        = 32;
	localparam int LEN_W       = 33;
	localparam int PA_W        = 32;

	typedef enum logic [1:0] {
		ACT_MAP     = 2'd0,
		ACT_UNMAP   = 2'd1,
		ACT_REPROT  = 2'd2,
		ACT_QUERY   = 2'd3
	} action_t;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_INVAL    = 2'd1;
	localparam logic [1:0] STS_NO_TABLE = 2'd2;

	localparam logic CFG_RAM_BASE = 1'b0;
	localparam logic CFG_RAM_SIZE = 1'b1;

	// Second-level entry: valid bit, permissions and host frame.
	typedef struct packed {
		logic               valid;
		logic [PERM_W-1:0]  perm;
		logic [FRAME_W-1:0] frame;
	} l2_entry_t;

endpackage

`default_nettype wire

>>> sv/tlptm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tlptm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> sv/two_level_page_table_manager_unit.sv
// Top level of the two-level page table manager: control sequencer and table memories.
//
// Channel   Direction  Handshake                        Payload
// request   in         start, taken when busy is low    action, virt_address, range_length,
//                                                       phys_address, perm_bits
// result    out        done, one-cycle strobe           status, region_base, region_size,
//                                                       region_mapped, region_perms, host_frame
// config    in         cfg_wr_en, no wait               cfg_index, cfg_wr_data
//
// Every request that passes its checks walks the table through the first-level memory and
// then, where the slot holds a table, the second-level memory, both with a registered read
// port. A map, unmap or reprotect checks every page of its range one at a time and then
// commits the range in a second pass; a failed check ends early. A query walks back and
// then forward from the queried page over the run that holds it, skipping an absent slot
// inside a hole as a whole. After reset a clearing pass sweeps both memories, one entry per
// cycle, over max(first-level slots, second-level depth) entries (65536 by default); busy
// stays high during the pass and configuration writes are taken as usual. The receiver
// cannot stall, so a result is shown for exactly one cycle, and busy drops in that cycle.
`default_nettype none

module two_level_page_table_manager_unit
	import tlptm_pkg::*;
#(
	parameter int ADDRESS_BITS      = DEF_ADDRESS_BITS,
	parameter int PAGE_BITS         = DEF_PAGE_BITS,
	parameter int SECOND_INDEX_BITS = DEF_SECOND_INDEX_BITS,
	parameter int TABLE_POOL        = DEF_TABLE_POOL
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            action,
	input  wire logic [VA_W-1:0]       virt_address,
	input  wire logic [LEN_W-1:0]      range_length,
	input  wire logic [PA_W-1:0]       phys_address,
	input  wire logic [3:0]            perm_bits,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [VA_W-1:0]            region_base,
	output logic [LEN_W-1:0]           region_size,
	output logic                       region_mapped,
	output logic [PERM_W-1:0]          region_perms,
	output logic [FRAME_W-1:0]         host_frame,
	input  wire logic                  cfg_wr_en,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_wr_data
);

	// Geometry derived from the parameters.
	localparam int VW       = ADDRESS_BITS - PAGE_BITS;          // page number width
	localparam int L1W      = VW - SECOND_INDEX_BITS;            // slot index width
	localparam int L1_COUNT = 1 << L1W;
	localparam int TW       = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
	localparam int L2AW     = TW + SECOND_INDEX_BITS;
	localparam int L2_DEPTH = 1 << L2AW;
	localparam int CNTW     = SECOND_INDEX_BITS + 1;             // mapped pages per slot
	localparam int FCW      = $clog2(TABLE_POOL + 1);
	localparam int ABW      = L1W + 1;
	localparam int CMPW     = (ABW > FCW + 1) ? ABW : FCW + 1;
	localparam int CLR_N    = (L1_COUNT > L2_DEPTH) ? L1_COUNT : L2_DEPTH;
	localparam int CLRW     = (CLR_N > 1) ? $clog2(CLR_N) : 1;
	localparam int BW       = ((ADDRESS_BITS > 33) ? ADDRESS_BITS : 33) + 2;
	localparam int L1WORD   = 1 + TW + CNTW;
	localparam int ENT_W    = 1 + PERM_W + FRAME_W;

	localparam logic [BW-1:0] SPACE_SIZE  = BW'(1) << ADDRESS_BITS;
	localparam logic [VW:0]   TOTAL_PAGES = {1'b1, {VW{1'b0}}};

	typedef struct packed {
		logic            valid;
		logic [TW-1:0]   tidx;
		logic [CNTW-1:0] cnt;
	} l1_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_RD1, ST_RD1D, ST_RD2D,
		ST_NEXT, ST_BACK0, ST_FWD0, ST_QDONE, ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		PH_SCAN, PH_COMMIT, PH_CENTER, PH_BACK, PH_FWD
	} phase_t;

	// Configuration registers.
	logic [RAM_BASE_W-1:0] base_q;
	logic [RAM_SIZE_W-1:0] rsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			rsize_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RAM_BASE: base_q  <= cfg_wr_data[RAM_BASE_W-1:0];
				CFG_RAM_SIZE: rsize_q <= cfg_wr_data[RAM_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state.
	state_t          state_q;
	phase_t          phase_q;
	logic [CLRW-1:0] clr_q;
	logic [FCW-1:0]  free_q;
	logic [FCW-1:0]  carved_q;
	logic [VW-1:0]   cur_q;
	logic [VW:0]     rem_q;
	logic            first_q;
	logic [ABW-1:0]  absent_q;
	logic [VW-1:0]   start_q;
	logic [VW:0]     end_q;
	logic [3:0]      key_q;
	logic [FRAME_W-1:0] frame_q;
	logic [1:0]      fin_q;

	// Latched request.
	action_t          act_q;
	logic [VA_W-1:0]  va_q;
	logic [LEN_W-1:0] len_q;
	logic [PA_W-1:0]  pa_q;
	logic [3:0]       perm_q;

	// Registered result.
	logic                done_q;
	logic [1:0]          status_q;
	logic [VA_W-1:0]     rbase_q;
	logic [LEN_W-1:0]    rsz_q;
	logic                rmapped_q;
	logic [PERM_W-1:0]   rperms_q;
	logic [FRAME_W-1:0]  rframe_q;

	// Memory ports.
	logic             l1_we, l1_re;
	logic [L1W-1:0]   l1_waddr, l1_raddr;
	l1_word_t         l1_wdata, l1_rd;
	logic             l2_we, l2_re;
	logic [L2AW-1:0]  l2_waddr, l2_raddr;
	l2_entry_t        l2_wdata, l2_rd;
	logic             stk_we, stk_re;
	logic [TW-1:0]    stk_waddr, stk_raddr;
	logic [TW-1:0]    stk_wdata, stk_rd;

	tlptm_ram #(.WIDTH(L1WORD), .DEPTH(L1_COUNT)) u_l1 (
		.clk     (clk),
		.wr_en   (l1_we),
		.wr_addr (l1_waddr),
		.wr_data (l1_wdata),
		.rd_en   (l1_re),
		.rd_addr (l1_raddr),
		.rd_data (l1_rd)
	);

	tlptm_ram #(.WIDTH(ENT_W), .DEPTH(L2_DEPTH)) u_l2 (
		.clk     (clk),
		.wr_en   (l2_we),
		.wr_addr (l2_waddr),
		.wr_data (l2_wdata),
		.rd_en   (l2_re),
		.rd_addr (l2_raddr),
		.rd_data (l2_rd)
	);

	tlptm_ram #(.WIDTH(TW), .DEPTH(TABLE_POOL)) u_stack (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (stk_waddr),
		.wr_data (stk_wdata),
		.rd_en   (stk_re),
		.rd_addr (stk_raddr),
		.rd_data (stk_rd)
	);

	// Argument checks on the latched request, all done in wide arithmetic.
	logic [BW-1:0]      va_b, len_b, pa_b, rs_b;
	logic               range_ok, phys_ok, perm_ok, in_space;
	logic [VW-1:0]      vpn_w;
	logic [VW:0]        cnt_w, vpn_p1_w, cur_p1_w;
	logic [FRAME_W-1:0] frame_init_w;

	always_comb begin
		va_b         = BW'(va_q);
		len_b        = BW'(len_q);
		pa_b         = BW'(pa_q);
		rs_b         = BW'(rsize_q);
		in_space     = va_b < SPACE_SIZE;
		range_ok     = (va_q[PAGE_BITS-1:0] == '0) && (len_q[PAGE_BITS-1:0] == '0) &&
			(len_q != '0) && in_space && (len_b <= SPACE_SIZE - va_b);
		phys_ok      = (pa_q[PAGE_BITS-1:0] == '0) && (pa_b < rs_b) &&
			(len_b <= rs_b - pa_b);
		perm_ok      = !perm_q[3];
		vpn_w        = VW'(va_b >> PAGE_BITS);
		cnt_w        = (VW+1)'(len_b >> PAGE_BITS);
		vpn_p1_w     = {1'b0, vpn_w} + (VW+1)'(1);
		cur_p1_w     = {1'b0, cur_q} + (VW+1)'(1);
		frame_init_w = FRAME_W'(BW'(base_q) + (pa_b >> PAGE_BITS));
	end

	// Page walk helpers.
	logic [L1W-1:0]              slot_w;
	logic [SECOND_INDEX_BITS-1:0] low_w;
	logic [L1W:0]                slot_p1_w;
	logic [VW:0]                 nend_w;
	logic [VW-1:0]               sbase_w;
	logic [CNTW-1:0]             dec_cnt_w;
	logic [TW-1:0]               alloc_w;
	logic [3:0]                  key_e_w;
	logic                        hole_w;
	logic                        absent_inc_w;
	logic [CMPW-1:0]             avail_w;

	always_comb begin
		slot_w       = cur_q[VW-1:SECOND_INDEX_BITS];
		low_w        = cur_q[SECOND_INDEX_BITS-1:0];
		slot_p1_w    = {1'b0, slot_w} + (L1W+1)'(1);
		nend_w       = {slot_p1_w, {SECOND_INDEX_BITS{1'b0}}};
		sbase_w      = {slot_w, {SECOND_INDEX_BITS{1'b0}}};
		dec_cnt_w    = (l1_rd.cnt != '0) ? l1_rd.cnt - CNTW'(1) : '0;
		alloc_w      = l1_rd.valid ? l1_rd.tidx :
			((free_q != '0) ? stk_rd : carved_q[TW-1:0]);
		key_e_w      = l2_rd.valid ? {1'b1, l2_rd.perm} : 4'd0;
		hole_w       = !key_q[3];
		absent_inc_w = (phase_q == PH_SCAN) && (act_q == ACT_MAP) &&
			(first_q || (low_w == '0)) && !l1_rd.valid;
		avail_w      = CMPW'(free_q) + CMPW'(TABLE_POOL) - CMPW'(carved_q);
	end

	// Memory control.
	always_comb begin
		l1_re     = (state_q == ST_RD1);
		l1_raddr  = slot_w;
		l1_we     = 1'b0;
		l1_waddr  = slot_w;
		l1_wdata  = '0;
		l2_re     = (state_q == ST_RD1D);
		l2_raddr  = {l1_rd.tidx, low_w};
		l2_we     = 1'b0;
		l2_waddr  = {l1_rd.tidx, low_w};
		l2_wdata  = '0;
		stk_re    = (state_q == ST_RD1);
		stk_raddr = TW'(free_q - FCW'(1));
		stk_we    = 1'b0;
		stk_waddr = free_q[TW-1:0];
		stk_wdata = l1_rd.tidx;
		unique case (state_q)
			ST_CLEAR: begin
				l1_we    = ({1'b0, clr_q} < (CLRW+1)'(L1_COUNT));
				l1_waddr = clr_q[L1W-1:0];
				l2_we    = ({1'b0, clr_q} < (CLRW+1)'(L2_DEPTH));
				l2_waddr = clr_q[L2AW-1:0];
			end
			ST_RD1D: begin
				if (phase_q == PH_COMMIT && act_q == ACT_MAP) begin
					// Take a table for an absent slot, then store the new entry.
					l1_we          = 1'b1;
					l1_wdata.valid = 1'b1;
					l1_wdata.tidx  = alloc_w;
					l1_wdata.cnt   = l1_rd.valid ? l1_rd.cnt + CNTW'(1) : CNTW'(1);
					l2_we          = 1'b1;
					l2_waddr       = {alloc_w, low_w};
					l2_wdata.valid = 1'b1;
					l2_wdata.perm  = perm_q[PERM_W-1:0];
					l2_wdata.frame = frame_q;
				end else if (phase_q == PH_COMMIT && act_q == ACT_UNMAP) begin
					// Clear the entry; a slot whose count drops to zero gives its table back.
					l2_we = 1'b1;
					l1_we = 1'b1;
					if (dec_cnt_w == '0) begin
						stk_we = ({1'b0, free_q} < (FCW+1)'(TABLE_POOL));
					end else begin
						l1_wdata.valid = 1'b1;
						l1_wdata.tidx  = l1_rd.tidx;
						l1_wdata.cnt   = dec_cnt_w;
					end
				end
			end
			ST_RD2D: begin
				if (phase_q == PH_COMMIT) begin
					l2_we          = 1'b1;
					l2_wdata.valid = l2_rd.valid;
					l2_wdata.perm  = perm_q[PERM_W-1:0];
					l2_wdata.frame = l2_rd.frame;
				end
			end
			default: ;
		endcase
	end

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			phase_q   <= PH_SCAN;
			clr_q     <= '0;
			free_q    <= '0;
			carved_q  <= '0;
			cur_q     <= '0;
			rem_q     <= '0;
			first_q   <= 1'b0;
			absent_q  <= '0;
			fin_q     <= STS_OK;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLRW'(1);
					if (clr_q == CLRW'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						act_q   <= action_t'(action);
						va_q    <= virt_address;
						len_q   <= range_length;
						pa_q    <= phys_address;
						perm_q  <= perm_bits;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					first_q  <= 1'b1;
					cur_q    <= vpn_w;
					rem_q    <= cnt_w;
					absent_q <= '0;
					phase_q  <= PH_SCAN;
					frame_q  <= frame_init_w;
					state_q  <= ST_RD1;
					fin_q    <= STS_INVAL;
					unique case (act_q)
						ACT_QUERY: begin
							phase_q <= PH_CENTER;
							if (!in_space) state_q <= ST_FIN;
						end
						ACT_MAP: begin
							if (!(range_ok && phys_ok && perm_ok)) state_q <= ST_FIN;
						end
						ACT_UNMAP: begin
							if (!range_ok) state_q <= ST_FIN;
						end
						ACT_REPROT: begin
							if (!(range_ok && perm_ok)) state_q <= ST_FIN;
						end
						default: ;
					endcase
				end
				ST_RD1: begin
					state_q <= ST_RD1D;
				end
				ST_RD1D: begin
					unique case (phase_q)
						PH_SCAN: begin
							if (absent_inc_w) absent_q <= absent_q + ABW'(1);
							if (l1_rd.valid) begin
								state_q <= ST_RD2D;
							end else if (act_q == ACT_MAP) begin
								state_q <= ST_NEXT;
							end else begin
								fin_q   <= STS_INVAL;
								state_q <= ST_FIN;
							end
						end
						PH_COMMIT: begin
							if (act_q == ACT_MAP) begin
								if (!l1_rd.valid) begin
									if (free_q != '0) free_q <= free_q - FCW'(1);
									else carved_q <= carved_q + FCW'(1);
								end
								frame_q <= frame_q + FRAME_W'(1);
								state_q <= ST_NEXT;
							end else if (act_q == ACT_UNMAP) begin
								if (dec_cnt_w == '0 && ({1'b0, free_q} < (FCW+1)'(TABLE_POOL)))
									free_q <= free_q + FCW'(1);
								state_q <= ST_NEXT;
							end else begin
								state_q <= ST_RD2D;
							end
						end
						PH_CENTER: begin
							if (l1_rd.valid) begin
								state_q <= ST_RD2D;
							end else begin
								key_q   <= 4'd0;
								frame_q <= '0;
								state_q <= ST_BACK0;
							end
						end
						PH_BACK: begin
							if (l1_rd.valid) begin
								state_q <= ST_RD2D;
							end else if (hole_w) begin
								// A whole absent slot belongs to the hole.
								start_q <= sbase_w;
								if (sbase_w != '0) begin
									cur_q   <= sbase_w - VW'(1);
									state_q <= ST_RD1;
								end else begin
									state_q <= ST_FWD0;
								end
							end else begin
								state_q <= ST_FWD0;
							end
						end
						PH_FWD: begin
							if (l1_rd.valid) begin
								state_q <= ST_RD2D;
							end else if (hole_w) begin
								end_q <= nend_w;
								if (nend_w < TOTAL_PAGES) begin
									cur_q   <= nend_w[VW-1:0];
									state_q <= ST_RD1;
								end else begin
									state_q <= ST_QDONE;
								end
							end else begin
								state_q <= ST_QDONE;
							end
						end
						default: ;
					endcase
				end
				ST_RD2D: begin
					unique case (phase_q)
						PH_SCAN: begin
							if (l2_rd.valid == (act_q == ACT_MAP)) begin
								fin_q   <= STS_INVAL;
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_NEXT;
							end
						end
						PH_COMMIT: begin
							state_q <= ST_NEXT;
						end
						PH_CENTER: begin
							key_q   <= key_e_w;
							frame_q <= l2_rd.frame;
							state_q <= ST_BACK0;
						end
						PH_BACK: begin
							if (key_e_w != key_q) begin
								state_q <= ST_FWD0;
							end else begin
								start_q <= cur_q;
								if (cur_q != '0) begin
									cur_q   <= cur_q - VW'(1);
									state_q <= ST_RD1;
								end else begin
									state_q <= ST_FWD0;
								end
							end
						end
						PH_FWD: begin
							if (key_e_w != key_q) begin
								state_q <= ST_QDONE;
							end else begin
								end_q <= cur_p1_w;
								if (cur_p1_w < TOTAL_PAGES) begin
									cur_q   <= cur_p1_w[VW-1:0];
									state_q <= ST_RD1;
								end else begin
									state_q <= ST_QDONE;
								end
							end
						end
						default: ;
					endcase
				end
				ST_NEXT: begin
					if (rem_q == (VW+1)'(1)) begin
						if (phase_q == PH_SCAN) begin
							if (act_q == ACT_MAP && CMPW'(absent_q) > avail_w) begin
								fin_q   <= STS_NO_TABLE;
								state_q <= ST_FIN;
							end else begin
								phase_q <= PH_COMMIT;
								cur_q   <= vpn_w;
								rem_q   <= cnt_w;
								state_q <= ST_RD1;
							end
						end else begin
							fin_q   <= STS_OK;
							state_q <= ST_FIN;
						end
					end else begin
						cur_q   <= cur_q + VW'(1);
						rem_q   <= rem_q - (VW+1)'(1);
						first_q <= 1'b0;
						state_q <= ST_RD1;
					end
				end
				ST_BACK0: begin
					start_q <= vpn_w;
					if (vpn_w != '0) begin
						cur_q   <= vpn_w - VW'(1);
						phase_q <= PH_BACK;
						state_q <= ST_RD1;
					end else begin
						state_q <= ST_FWD0;
					end
				end
				ST_FWD0: begin
					end_q <= vpn_p1_w;
					if (vpn_p1_w < TOTAL_PAGES) begin
						cur_q   <= vpn_p1_w[VW-1:0];
						phase_q <= PH_FWD;
						state_q <= ST_RD1;
					end else begin
						state_q <= ST_QDONE;
					end
				end
				ST_QDONE: begin
					done_q    <= 1'b1;
					status_q  <= STS_OK;
					rbase_q   <= VA_W'(BW'(start_q) << PAGE_BITS);
					rsz_q     <= LEN_W'(BW'(end_q - {1'b0, start_q}) << PAGE_BITS);
					rmapped_q <= key_q[3];
					rperms_q  <= key_q[PERM_W-1:0];
					rframe_q  <= key_q[3] ? frame_q : '0;
					state_q   <= ST_IDLE;
				end
				ST_FIN: begin
					done_q    <= 1'b1;
					status_q  <= fin_q;
					rbase_q   <= '0;
					rsz_q     <= '0;
					rmapped_q <= 1'b0;
					rperms_q  <= '0;
					rframe_q  <= '0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign region_base   = rbase_q;
	assign region_size   = rsz_q;
	assign region_mapped = rmapped_q;
	assign region_perms  = rperms_q;
	assign host_frame    = rframe_q;

`ifndef NO_ASSERTIONS
	// A result strobe always comes with the block ready for the next request.
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// Every table on the free stack was carved first, and no more than the pool.
	a_pool_count: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q <= carved_q) && (carved_q <= FCW'(TABLE_POOL)))
		else $error("table pool accounting broken");

	// An accepted request keeps the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request accepted but block not busy");

	// Only defined status codes are reported.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STS_OK || status == STS_INVAL || status == STS_NO_TABLE))
		else $error("undefined status code");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the two-level page table manager unit.
`default_nettype none

module tb_top;
	import tlptm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = 1024;
	localparam int TBL_PAGES = 1024;
	localparam int POOL      = 64;
	localparam longint unsigned SPACE = 64'h1_0000_0000;
	localparam longint unsigned PAGES = 64'h10_0000;
	localparam int CYCLE_LIMIT = 30_000_000;
	localparam int RANDOM_ITEMS = 1330;

	// One result transaction as the block reports it.
	typedef struct {
		logic [1:0]         sts;
		logic [VA_W-1:0]    base;
		logic [LEN_W-1:0]   size;
		logic               mapped;
		logic [PERM_W-1:0]  perms;
		logic [FRAME_W-1:0] frame;
	} outcome_t;

	// One request transaction.
	typedef struct {
		action_t           act;
		logic [VA_W-1:0]   va;
		logic [LEN_W-1:0]  len;
		logic [PA_W-1:0]   pa;
		logic [3:0]        perm;
	} request_t;

	// A row of the directed table: the request and, where it is obvious, its result.
	typedef struct {
		request_t req;
		bit       typed;
		outcome_t res;
	} directed_row_t;

	typedef struct {
		longint unsigned vpn;
		longint unsigned cnt;
	} extent_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] action = ACT_MAP;
	logic [VA_W-1:0] virt_address = '0;
	logic [LEN_W-1:0] range_length = '0;
	logic [PA_W-1:0] phys_address = '0;
	logic [3:0] perm_bits = '0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = CFG_RAM_BASE;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	wire busy, done, region_mapped;
	wire [1:0] status;
	wire [VA_W-1:0] region_base;
	wire [LEN_W-1:0] region_size;
	wire [PERM_W-1:0] region_perms;
	wire [FRAME_W-1:0] host_frame;

	two_level_page_table_manager_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .virt_address(virt_address), .range_length(range_length),
		.phys_address(phys_address), .perm_bits(perm_bits),
		.done(done), .status(status), .region_base(region_base),
		.region_size(region_size), .region_mapped(region_mapped),
		.region_perms(region_perms), .host_frame(host_frame),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the page tables and the pool bookkeeping.
	bit              slot_present [SLOTS];
	bit [15:0]       slot_table   [SLOTS];
	bit [24:0]       leaf_entry   [POOL*TBL_PAGES];
	int unsigned     slot_pages   [SLOTS];
	bit [5:0]        free_tables  [POOL];
	int unsigned     free_depth;
	int unsigned     carved_tables;
	bit [19:0]       shadow_ram_base;
	bit [32:0]       shadow_ram_size;

	outcome_t pending_results[$];
	directed_row_t directed[$];
	extent_t live_maps[$];
	int mismatches = 0;
	int cycles = 0;

	function automatic longint unsigned slot_of(longint unsigned vpn);
		return (vpn >> 10) & (SLOTS - 1);
	endfunction

	function automatic bit [24:0] leaf_read(longint unsigned vpn);
		longint unsigned sl;
		sl = slot_of(vpn);
		if (!slot_present[sl] || slot_table[sl] >= POOL) return '0;
		return leaf_entry[slot_table[sl]*TBL_PAGES + (vpn & (TBL_PAGES - 1))];
	endfunction

	function automatic void leaf_write(longint unsigned vpn, bit [24:0] e);
		longint unsigned sl;
		sl = slot_of(vpn);
		if (slot_present[sl] && slot_table[sl] < POOL)
			leaf_entry[slot_table[sl]*TBL_PAGES + (vpn & (TBL_PAGES - 1))] = e;
	endfunction

	// Run key: zero for a hole, else the mapped flag plus permissions.
	function automatic bit [3:0] run_key(longint unsigned vpn);
		bit [24:0] e;
		e = leaf_read(vpn);
		if (!e[24]) return 4'd0;
		return {1'b1, e[23:21]};
	endfunction

	function automatic bit range_ok(longint unsigned va, longint unsigned sz);
		return (va & 12'hFFF) == 0 && (sz & 12'hFFF) == 0 && sz > 0 &&
			va < SPACE && sz <= SPACE - va;
	endfunction

	function automatic bit every_page_mapped(longint unsigned vpn, longint unsigned cnt);
		bit [24:0] e;
		for (longint unsigned i = 0; i < cnt; i++) begin
			e = leaf_read(vpn + i);
			if (!e[24]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic int unsigned claim_table();
		int unsigned t;
		if (free_depth > 0) begin
			free_depth--;
			return free_tables[free_depth];
		end
		t = carved_tables;
		carved_tables++;
		return t;
	endfunction

	function automatic logic [1:0] apply_map(longint unsigned va, longint unsigned sz,
			longint unsigned pa, longint unsigned perm);
		longint unsigned vpn, cnt, absent, avail, sl, frame;
		bit [24:0] e;
		vpn = va >> 12;
		cnt = sz >> 12;
		absent = 0;
		if (!range_ok(va, sz)) return STS_INVAL;
		if ((pa & 12'hFFF) != 0 || pa >= shadow_ram_size || sz > shadow_ram_size - pa)
			return STS_INVAL;
		if (perm > 7) return STS_INVAL;
		for (longint unsigned i = 0; i < cnt; i++) begin
			e = leaf_read(vpn + i);
			if (e[24]) return STS_INVAL;
		end
		for (longint unsigned s = vpn >> 10; s <= (vpn + cnt - 1) >> 10; s++)
			if (!slot_present[s & (SLOTS - 1)]) absent++;
		avail = free_depth + (POOL - carved_tables);
		if (absent > avail) return STS_NO_TABLE;
		for (longint unsigned i = 0; i < cnt; i++) begin
			sl = slot_of(vpn + i);
			frame = (shadow_ram_base + (pa >> 12) + i) & 21'h1FFFFF;
			if (!slot_present[sl]) begin
				slot_present[sl] = 1'b1;
				slot_table[sl] = 16'(claim_table());
			end
			leaf_write(vpn + i, {1'b1, perm[2:0], frame[20:0]});
			slot_pages[sl]++;
		end
		return STS_OK;
	endfunction

	function automatic logic [1:0] apply_unmap(longint unsigned va, longint unsigned sz);
		longint unsigned vpn, cnt, sl;
		vpn = va >> 12;
		cnt = sz >> 12;
		if (!range_ok(va, sz) || !every_page_mapped(vpn, cnt)) return STS_INVAL;
		for (longint unsigned i = 0; i < cnt; i++) begin
			sl = slot_of(vpn + i);
			leaf_write(vpn + i, '0);
			if (slot_pages[sl] > 0) slot_pages[sl]--;
			if (slot_pages[sl] == 0) begin
				if (free_depth < POOL) begin
					free_tables[free_depth] = slot_table[sl][5:0];
					free_depth++;
				end
				slot_present[sl] = 1'b0;
				slot_table[sl] = '0;
			end
		end
		return STS_OK;
	endfunction

	function automatic logic [1:0] apply_reprotect(longint unsigned va, longint unsigned sz,
			longint unsigned perm);
		longint unsigned vpn, cnt;
		bit [24:0] e;
		vpn = va >> 12;
		cnt = sz >> 12;
		if (perm > 7) return STS_INVAL;
		if (!range_ok(va, sz) || !every_page_mapped(vpn, cnt)) return STS_INVAL;
		for (longint unsigned i = 0; i < cnt; i++) begin
			e = leaf_read(vpn + i);
			e[23:21] = perm[2:0];
			leaf_write(vpn + i, e);
		end
		return STS_OK;
	endfunction

	// Walks outward from the queried page while the run key stays the same; inside a
	// hole, absent slots are skipped whole.
	function automatic outcome_t region_around(longint unsigned va);
		outcome_t r;
		longint unsigned vpn, lo, hi, p;
		bit [3:0] key;
		bit hole;
		bit [24:0] e;
		vpn = va >> 12;
		key = run_key(vpn);
		hole = (key == 0);
		lo = vpn;
		while (lo > 0) begin
			p = lo - 1;
			if (hole && !slot_present[slot_of(p)]) begin
				lo = (p >> 10) << 10;
				continue;
			end
			if (run_key(p) != key) break;
			lo--;
		end
		hi = vpn + 1;
		while (hi < PAGES) begin
			if (hole && !slot_present[slot_of(hi)]) begin
				hi = ((hi >> 10) + 1) << 10;
				continue;
			end
			if (run_key(hi) != key) break;
			hi++;
		end
		e = leaf_read(vpn);
		r.sts = STS_OK;
		r.base = 32'(lo << 12);
		r.size = 33'((hi - lo) << 12);
		r.mapped = !hole;
		r.perms = hole ? '0 : key[2:0];
		r.frame = hole ? '0 : e[20:0];
		return r;
	endfunction

	// Computes the result of one request and advances the shadow state.
	function automatic outcome_t predict_outcome(request_t q);
		outcome_t r;
		r = '{default: '0};
		case (q.act)
			ACT_MAP: r.sts = apply_map(q.va, q.len, q.pa, q.perm);
			ACT_UNMAP: r.sts = apply_unmap(q.va, q.len);
			ACT_REPROT: r.sts = apply_reprotect(q.va, q.len, q.perm);
			default: r = region_around(q.va);
		endcase
		if (q.act == ACT_MAP && r.sts == STS_OK) begin
			live_maps.push_back('{q.va >> 12, q.len >> 12});
			if (live_maps.size() > 32) void'(live_maps.pop_front());
		end
		return r;
	endfunction

	// Gap length: mostly zero or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 120);
	endfunction

	// Drives one request transaction and waits until the block takes it.
	task automatic send_request(request_t q, bit typed, outcome_t typed_res);
		int gap;
		outcome_t r;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		action = q.act;
		virt_address = q.va;
		range_length = q.len;
		phys_address = q.pa;
		perm_bits = q.perm;
		start = 1'b1;
		do @(posedge clk); while (busy);
		// Accepted at this edge; the predictor runs even when the result is typed in.
		r = predict_outcome(q);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	// Lowers start and waits until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(logic idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wr_data = data;
		if (idx == CFG_RAM_BASE) shadow_ram_base = data[19:0];
		else shadow_ram_size = data[32:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic add_row(action_t a, logic [31:0] va, logic [32:0] len, logic [31:0] pa,
			logic [3:0] perm, bit typed, outcome_t res);
		directed_row_t d;
		d.req = '{a, va, len, pa, perm};
		d.typed = typed;
		d.res = res;
		directed.push_back(d);
	endtask

	// Builds a random request. Most are well formed and aimed at a few slots so that
	// maps, unmaps and reprotects actually get past their checks.
	function automatic request_t random_request();
		request_t q;
		longint unsigned slot, vpn, cnt, pages_ram;
		int r, pick;
		extent_t x;
		r = $urandom_range(0, 99);
		q.act = r < 35 ? ACT_MAP : r < 60 ? ACT_UNMAP : r < 75 ? ACT_REPROT : ACT_QUERY;
		q.perm = $urandom_range(0, 99) < 95 ? 4'($urandom_range(0, 7)) :
			4'($urandom_range(8, 15));
		q.pa = $urandom;
		if ($urandom_range(0, 99) < 12) begin
			// Noise: any value in any field.
			q.va = $urandom;
			q.len = {1'($urandom_range(0, 1)), 32'($urandom)};
			if ($urandom_range(0, 3) == 0) q.len = q.len & 33'h1_FFFF_F000;
			if ($urandom_range(0, 3) == 0) q.va = q.va & 32'hFFFF_F000;
			return q;
		end
		pick = $urandom_range(0, 5);
		slot = pick < 4 ? pick : pick == 4 ? SLOTS - 1 : $urandom_range(0, SLOTS - 1);
		vpn = slot * TBL_PAGES + ($urandom_range(0, 1) ? $urandom_range(1016, 1023) :
			$urandom_range(0, TBL_PAGES - 1));
		cnt = $urandom_range(0, 99) < 95 ? $urandom_range(1, 8) : $urandom_range(9, 300);
		if ((q.act == ACT_UNMAP || q.act == ACT_REPROT || q.act == ACT_QUERY) &&
				live_maps.size() > 0 && $urandom_range(0, 99) < 75) begin
			x = live_maps[$urandom_range(0, live_maps.size() - 1)];
			vpn = x.vpn;
			cnt = x.cnt;
			if ($urandom_range(0, 3) == 0) begin
				vpn = vpn + $urandom_range(0, cnt - 1);
				cnt = $urandom_range(1, x.vpn + x.cnt - vpn);
			end
		end
		if (vpn + cnt > PAGES) cnt = PAGES - vpn;
		q.va = 32'(vpn << 12);
		q.len = 33'(cnt << 12);
		if (q.act == ACT_QUERY) begin
			q.va = 32'(((vpn + $urandom_range(0, cnt - 1)) << 12) | 12'($urandom));
			if ($urandom_range(0, 4) == 0) q.va = $urandom;
		end
		pages_ram = shadow_ram_size >> 12;
		if (pages_ram > 0 && $urandom_range(0, 9) != 0)
			q.pa = 32'((longint'($urandom) % pages_ram) << 12);
		return q;
	endfunction

	// Result checker: each strobed result is compared with the oldest expectation.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction, status %0d", status);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.sts || region_base !== want.base ||
						region_size !== want.size || region_mapped !== want.mapped ||
						region_perms !== want.perms || host_frame !== want.frame) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected sts %0d base %h size %h map %0d ",
							want.sts, want.base, want.size, want.mapped,
							"perm %0d fr %h, got sts %0d base %h size %h ",
							want.perms, want.frame, status, region_base, region_size,
							"map %0d perm %0d fr %h",
							region_mapped, region_perms, host_frame);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		outcome_t none, whole, bad, no_tbl;
		none = '{default: '0};
		whole = '{STS_OK, 32'h0, 33'h1_0000_0000, 1'b0, 3'd0, 21'd0};
		bad = '{default: '0};
		bad.sts = STS_INVAL;
		no_tbl = '{default: '0};
		no_tbl.sts = STS_NO_TABLE;

		shadow_ram_base = '0;
		shadow_ram_size = '0;
		free_depth = 0;
		carved_tables = 0;
		foreach (slot_present[i]) begin
			slot_present[i] = 1'b0;
			slot_table[i] = '0;
			slot_pages[i] = 0;
		end
		foreach (leaf_entry[i]) leaf_entry[i] = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The block is still sweeping its memories; register writes are taken anyway.
		write_register(CFG_RAM_BASE, 33'h0_000F_FFFF);
		write_register(CFG_RAM_SIZE, 33'h1_0000_0000);

		// Directed part: empty space, extremes of every field, and each error case.
		add_row(ACT_QUERY, 32'h0, 33'h0, 32'h0, 4'h0, 1, whole);
		add_row(ACT_QUERY, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1, whole);
		add_row(ACT_MAP, 32'h0, 33'h1000, 32'h0, 4'h7, 0, none);
		add_row(ACT_QUERY, 32'h0000_0ABC, 33'h0, 32'h0, 4'h0, 0, none);
		// Whole-space map collides with page zero; whole-space unmap hits a hole.
		add_row(ACT_MAP, 32'h0, 33'h1_0000_0000, 32'h0, 4'h1, 1, bad);
		add_row(ACT_UNMAP, 32'h0, 33'h1_0000_0000, 32'h0, 4'h0, 1, bad);
		add_row(ACT_MAP, 32'h0000_1001, 33'h1000, 32'h0, 4'h1, 1, bad);
		add_row(ACT_MAP, 32'h0000_1000, 33'h0, 32'h0, 4'h1, 1, bad);
		add_row(ACT_MAP, 32'hFFFF_F000, 33'h2000, 32'h0, 4'h1, 1, bad);
		add_row(ACT_MAP, 32'h0000_1000, 33'h1000, 32'h0000_0800, 4'h1, 1, bad);
		add_row(ACT_MAP, 32'h0000_1000, 33'h1000, 32'h0, 4'h8, 1, bad);
		add_row(ACT_REPROT, 32'h0, 33'h1000, 32'h0, 4'hF, 1, bad);
		add_row(ACT_REPROT, 32'h0, 33'h1000, 32'hFFFF_FFFF, 4'h2, 0, none);
		add_row(ACT_UNMAP, 32'h0000_5000, 33'h1000, 32'h0, 4'h0, 1, bad);
		// Map straddling a slot boundary, backed at the top of guest RAM.
		add_row(ACT_MAP, 32'h003F_F000, 33'h2000, 32'hFFFF_E000, 4'h5, 0, none);
		add_row(ACT_QUERY, 32'h0040_0000, 33'h0, 32'h0, 4'h0, 0, none);
		add_row(ACT_MAP, 32'hFFFF_F000, 33'h1000, 32'h0000_1000, 4'h0, 0, none);
		add_row(ACT_QUERY, 32'hFFFF_FFFF, 33'h0, 32'h0, 4'h0, 0, none);
		// Spans 65 absent slots, more than the pool can still supply.
		add_row(ACT_MAP, 32'h1000_0000, 33'h1040_0000, 32'h0, 4'h3, 1, no_tbl);
		add_row(ACT_UNMAP, 32'h0, 33'h1000, 32'h0, 4'h0, 0, none);
		add_row(ACT_UNMAP, 32'h003F_F000, 33'h2000, 32'h0, 4'h0, 0, none);
		add_row(ACT_QUERY, 32'h0000_1000, 33'h0, 32'h0, 4'h0, 0, none);
		add_row(ACT_REPROT, 32'hFFFF_F000, 33'h1000, 32'h0, 4'h7, 0, none);
		add_row(ACT_QUERY, 32'h1234_5678, 33'h0, 32'h0, 4'h0, 0, none);

		foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].res);
		drain();

		// Random part in four register settings: full RAM, no RAM, small RAM, and a
		// random size.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_register(CFG_RAM_BASE, 33'($urandom_range(0, 20'hFFFFF)));
					write_register(CFG_RAM_SIZE, 33'h1_0000_0000);
				end
				1: begin
					write_register(CFG_RAM_BASE, 33'h0);
					write_register(CFG_RAM_SIZE, 33'h0);
				end
				2: begin
					write_register(CFG_RAM_BASE, 33'h0_000F_FFFF);
					write_register(CFG_RAM_SIZE, 33'($urandom_range(1, 64)) << 12);
				end
				default: begin
					write_register(CFG_RAM_BASE, 33'($urandom));
					write_register(CFG_RAM_SIZE, {1'b0, 32'($urandom)});
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				// Once per phase the sender holds off until the block has answered everything.
				if (n == RANDOM_ITEMS / 8) drain();
				send_request(random_request(), 0, none);
			end
			drain();
		end

		repeat (200) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
